FILE: design/wsd_pkg.sv
// Package for the WebSocket frame deframer: parse phases, queue entry type
// and header constants. Used by the front end, back end and top level; depends on nothing.
`default_nettype none

package wsd_pkg;

   // Parse phases of the byte stream
   typedef enum logic [2:0] {
      PH_B0    = 3'd0,
      PH_B1    = 3'd1,
      PH_EXT16 = 3'd2,
      PH_EXT64 = 3'd3,
      PH_MASK  = 3'd4,
      PH_DATA  = 3'd5
   } phase_type;

   // Header field constants
   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;
   localparam logic [2:0] EXT16_LAST_CNT = 3'd1;   // second length byte
   localparam logic [2:0] EXT64_LAST_CNT = 3'd7;   // eighth length byte
   localparam logic [2:0] MASK_LAST_CNT  = 3'd3;   // fourth key byte

   // One classified payload beat, still masked, handed to the back end
   typedef struct packed {
      logic [7:0] data_byte;
      logic [7:0] key_byte;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
   } entry_type;

endpackage

`default_nettype wire

FILE: design/wsd_queue.sv
// Small FIFO between the header parser and the output stage.
// Generic width and depth; no package dependency.
`default_nettype none

module wsd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic             not_empty,
   output      logic [WIDTH-1:0] pop_data
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrMax = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CntFull);
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = store_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrMax) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrMax) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: design/wsd_front.sv
// Front end: walks the frame header byte by byte and tags payload beats.
// Depends on wsd_pkg for phase codes, constants and the entry type.
`default_nettype none

module wsd_front (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               take,        // byte accepted this cycle
   input  wire logic [7:0]         rx_byte,
   output      logic               push,
   output      wsd_pkg::entry_type push_entry
);

   wsd_pkg::phase_type phase_ff, phase_in;
   logic [2:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [63:0] remain_ff, remain_in;
   logic [31:0] key_ff, key_in;
   logic [1:0]  pos_ff, pos_in;
   logic        mask_en_ff, mask_en_in;
   logic [3:0]  opcode_ff, opcode_in;
   logic        fin_ff, fin_in;

   logic [63:0] remain_shift;
   logic [63:0] remain_dec;
   logic        dec_zero;
   logic [6:0]  len_code;
   logic [7:0]  key_sel;

   assign remain_shift = {remain_ff[55:0], rx_byte};
   assign remain_dec   = remain_ff - 64'd1;
   assign dec_zero     = (remain_dec == '0);
   assign len_code     = rx_byte[6:0];

   // key byte for this payload position, first key byte at position zero
   always_comb begin
      case (pos_ff)
         2'd0:    key_sel = key_ff[31:24];
         2'd1:    key_sel = key_ff[23:16];
         2'd2:    key_sel = key_ff[15:8];
         default: key_sel = key_ff[7:0];
      endcase
   end

   // header walk: next state
   always_comb begin
      phase_in   = phase_ff;
      hdr_cnt_in = hdr_cnt_ff;
      remain_in  = remain_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      mask_en_in = mask_en_ff;
      opcode_in  = opcode_ff;
      fin_in     = fin_ff;
      if (take) begin
         case (phase_ff)
            wsd_pkg::PH_B1: begin
               mask_en_in = rx_byte[7];
               hdr_cnt_in = '0;
               pos_in     = '0;
               if (len_code == wsd_pkg::LEN_CODE_EXT16) begin
                  remain_in = '0;
                  phase_in  = wsd_pkg::PH_EXT16;
               end else if (len_code == wsd_pkg::LEN_CODE_EXT64) begin
                  remain_in = '0;
                  phase_in  = wsd_pkg::PH_EXT64;
               end else begin
                  remain_in = {57'd0, len_code};
                  if (rx_byte[7]) begin
                     phase_in = wsd_pkg::PH_MASK;
                  end else if (len_code == '0) begin
                     phase_in = wsd_pkg::PH_B0;
                  end else begin
                     phase_in = wsd_pkg::PH_DATA;
                  end
               end
            end
            wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
               remain_in  = remain_shift;
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
               if ((phase_ff == wsd_pkg::PH_EXT16 && hdr_cnt_ff == wsd_pkg::EXT16_LAST_CNT) ||
                   (phase_ff == wsd_pkg::PH_EXT64 && hdr_cnt_ff == wsd_pkg::EXT64_LAST_CNT)) begin
                  hdr_cnt_in = '0;
                  pos_in     = '0;
                  if (mask_en_ff) begin
                     phase_in = wsd_pkg::PH_MASK;
                  end else if (remain_shift == '0) begin
                     phase_in = wsd_pkg::PH_B0;
                  end else begin
                     phase_in = wsd_pkg::PH_DATA;
                  end
               end
            end
            wsd_pkg::PH_MASK: begin
               key_in     = {key_ff[23:0], rx_byte};
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
               if (hdr_cnt_ff == wsd_pkg::MASK_LAST_CNT) begin
                  hdr_cnt_in = '0;
                  pos_in     = '0;
                  phase_in   = (remain_ff == '0) ? wsd_pkg::PH_B0 : wsd_pkg::PH_DATA;
               end
            end
            wsd_pkg::PH_DATA: begin
               remain_in = remain_dec;
               pos_in    = pos_ff + 2'd1;
               if (dec_zero) begin
                  phase_in = wsd_pkg::PH_B0;
               end
            end
            default: begin
               // first header byte
               fin_in    = rx_byte[7];
               opcode_in = rx_byte[3:0];
               phase_in  = wsd_pkg::PH_B1;
            end
         endcase
      end
   end

   // payload beat towards the queue
   always_comb begin
      push                 = take && (phase_ff == wsd_pkg::PH_DATA);
      push_entry.data_byte = rx_byte;
      push_entry.key_byte  = mask_en_ff ? key_sel : 8'd0;
      push_entry.opcode    = opcode_ff;
      push_entry.fin       = fin_ff;
      push_entry.last      = dec_zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= wsd_pkg::PH_B0;
         hdr_cnt_ff <= '0;
         remain_ff  <= '0;
         key_ff     <= '0;
         pos_ff     <= '0;
         mask_en_ff <= 1'b0;
         opcode_ff  <= '0;
         fin_ff     <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         hdr_cnt_ff <= hdr_cnt_in;
         remain_ff  <= remain_in;
         key_ff     <= key_in;
         pos_ff     <= pos_in;
         mask_en_ff <= mask_en_in;
         opcode_ff  <= opcode_in;
         fin_ff     <= fin_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/wsd_back.sv
// Back end: pops tagged payload beats, removes the mask and holds the
// result beat in an output register. Depends on wsd_pkg for the entry type.
`default_nettype none

module wsd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               entry_valid,
   input  wire wsd_pkg::entry_type entry,
   output      logic               pop,
   output      logic               out_valid,
   input  wire logic               out_ready,
   output      logic [7:0]         out_byte,
   output      logic [3:0]         out_opcode,
   output      logic               out_fin,
   output      logic               out_last
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic [3:0] opcode_ff, opcode_in;
   logic       fin_ff, fin_in;
   logic       last_ff, last_in;

   // refill the output register whenever it is empty or being drained
   assign pop = entry_valid && (!valid_ff || out_ready);

   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      opcode_in = opcode_ff;
      fin_in    = fin_ff;
      last_in   = last_ff;
      if (pop) begin
         valid_in  = 1'b1;
         byte_in   = entry.data_byte ^ entry.key_byte;
         opcode_in = entry.opcode;
         fin_in    = entry.fin;
         last_in   = entry.last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      opcode_ff <= opcode_in;
      fin_ff    <= fin_in;
      last_ff   <= last_in;
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_opcode = opcode_ff;
   assign out_fin    = fin_ff;
   assign out_last   = last_ff;

endmodule

`default_nettype wire

FILE: design/websocket_frame_deframer_unit.sv
// WebSocket frame deframer, top level: header parser, beat queue, output stage.
// Throughput: one byte per cycle while the queue has room, header and payload
// alike, set by the parser. A payload byte reaches rsp_ from its req_ beat by
// way of the queue and then the output register.
// Header bytes and empty frames give no rsp_ beat.
// Reset (synchronous, active high) clears parser state, queue and output valid.
`default_nettype none

module websocket_frame_deframer_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] rx_byte
   output      logic       rsp_tvalid,
   input  wire logic       rsp_tready,
   output      logic [7:0] rsp_tdata,   // [7:0] payload_byte
   output      logic [4:0] rsp_tuser,   // [3:0] frame_opcode, [4] frame_fin
   output      logic       rsp_tlast    // last_in_frame
);

   localparam int EntryW = $bits(wsd_pkg::entry_type);

   logic               take;
   logic               push;
   wsd_pkg::entry_type push_entry;
   wsd_pkg::entry_type pop_entry;
   logic [EntryW-1:0]  pop_bits;
   logic               q_full;
   logic               q_valid;
   logic               pop;
   logic [3:0]         out_opcode;
   logic               out_fin;

   // a beat is taken whenever the queue has room
   assign req_tready = !q_full;
   assign take       = req_tvalid && req_tready;

   wsd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .rx_byte    (req_tdata),
      .push       (push),
      .push_entry (push_entry)
   );

   wsd_queue #(
      .WIDTH (EntryW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_entry),
      .full      (q_full),
      .pop       (pop),
      .not_empty (q_valid),
      .pop_data  (pop_bits)
   );

   assign pop_entry = wsd_pkg::entry_type'(pop_bits);

   wsd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (q_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_opcode  (out_opcode),
      .out_fin     (out_fin),
      .out_last    (rsp_tlast)
   );

   assign rsp_tuser = {out_fin, out_opcode};

endmodule

`default_nettype wire

FILE: sim/websocket_frame_deframer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for websocket_frame_deframer_unit: a directed table, then random
// frame streams, checked beat by beat against a behavioural frame parser held in here.
// Depends on wsd_pkg (phase_type) and the deframer RTL only.

module websocket_frame_deframer_unit_tb;

   // Header length codes and the key length
   localparam logic [6:0] CODE_LEN16 = 7'd126;
   localparam logic [6:0] CODE_LEN64 = 7'd127;
   localparam int         KEY_BYTES  = 4;

   // One unmasked payload beat as it leaves the block
   typedef struct packed {
      logic [7:0] data;
      logic [3:0] opcode;
      logic       fin;
      logic       last;
   } payload_beat_type;

   // Directed rows either carry their result or leave it to the parser
   typedef enum bit { ROW_PREDICT, ROW_FIXED } row_kind_type;

   typedef struct packed {
      logic [7:0]       rx;
      row_kind_type     kind;
      payload_beat_type beat;
   } stim_row_type;

   localparam payload_beat_type NO_BEAT  = '0;
   localparam int               N_ROWS   = 25;

   logic       clock;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;    // [7:0] payload_byte
   logic [4:0] rsp_tuser;    // [3:0] frame_opcode, [4] frame_fin
   logic       rsp_tlast;    // last_in_frame

   // Parser state of the predictor
   wsd_pkg::phase_type ws_phase = wsd_pkg::PH_B0;
   logic [2:0]  hdr_cnt    = '0;
   logic [63:0] rem_len    = '0;
   logic [31:0] key_word   = '0;
   logic [1:0]  key_pos    = '0;
   logic        key_on     = 1'b0;
   logic [3:0]  frame_opc  = '0;
   logic        frame_fin  = 1'b0;

   payload_beat_type pending_beats[$];
   int               fail_count = 0;
   int               bytes_sent = 0;
   bit               no_idle    = 1'b0;

   // Directed stream: plain frame, empty frames, masked frame, 16-bit length
   stim_row_type directed_rows [0:N_ROWS-1] = '{
      // unmasked text frame, FIN, two bytes at the extremes
      '{8'h81, ROW_PREDICT, NO_BEAT},
      '{8'h02, ROW_PREDICT, NO_BEAT},
      '{8'h00, ROW_FIXED,   '{8'h00, 4'h1, 1'b1, 1'b0}},
      '{8'hFF, ROW_FIXED,   '{8'hFF, 4'h1, 1'b1, 1'b1}},
      // empty unmasked frame
      '{8'h09, ROW_PREDICT, NO_BEAT},
      '{8'h00, ROW_PREDICT, NO_BEAT},
      // empty masked frame, key only
      '{8'h8A, ROW_PREDICT, NO_BEAT},
      '{8'h80, ROW_PREDICT, NO_BEAT},
      '{8'h11, ROW_PREDICT, NO_BEAT},
      '{8'h22, ROW_PREDICT, NO_BEAT},
      '{8'h33, ROW_PREDICT, NO_BEAT},
      '{8'h44, ROW_PREDICT, NO_BEAT},
      // masked fragment, key FF 00 AA 55
      '{8'h02, ROW_PREDICT, NO_BEAT},
      '{8'h82, ROW_PREDICT, NO_BEAT},
      '{8'hFF, ROW_PREDICT, NO_BEAT},
      '{8'h00, ROW_PREDICT, NO_BEAT},
      '{8'hAA, ROW_PREDICT, NO_BEAT},
      '{8'h55, ROW_PREDICT, NO_BEAT},
      '{8'hFF, ROW_FIXED,   '{8'h00, 4'h2, 1'b0, 1'b0}},
      '{8'hFF, ROW_FIXED,   '{8'hFF, 4'h2, 1'b0, 1'b1}},
      // 16-bit length form, reserved bits set, one byte
      '{8'hF0, ROW_PREDICT, NO_BEAT},
      '{8'h7E, ROW_PREDICT, NO_BEAT},
      '{8'h00, ROW_PREDICT, NO_BEAT},
      '{8'h01, ROW_PREDICT, NO_BEAT},
      '{8'h5A, ROW_FIXED,   '{8'h5A, 4'h0, 1'b1, 1'b1}}
   };

   websocket_frame_deframer_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Length known: go to the key, the payload or straight back to byte 0
   function automatic void finish_length();
      hdr_cnt = '0;
      key_pos = '0;
      if (key_on)
         ws_phase = wsd_pkg::PH_MASK;
      else if (rem_len == 64'd0)
         ws_phase = wsd_pkg::PH_B0;
      else
         ws_phase = wsd_pkg::PH_DATA;
   endfunction

   // Parser step for one received byte; returns 1 when a payload beat results
   function automatic bit deframe_byte(input logic [7:0] rx, output payload_beat_type beat);
      logic [7:0] key_byte;
      logic [2:0] len_done;
      beat = NO_BEAT;
      case (ws_phase)
         wsd_pkg::PH_B1: begin
            key_on  = rx[7];
            rem_len = '0;
            hdr_cnt = '0;
            if (rx[6:0] == CODE_LEN16)
               ws_phase = wsd_pkg::PH_EXT16;
            else if (rx[6:0] == CODE_LEN64)
               ws_phase = wsd_pkg::PH_EXT64;
            else begin
               rem_len = {57'd0, rx[6:0]};
               finish_length();
            end
            return 1'b0;
         end
         wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
            // eight bytes wrap the 3-bit count back to zero
            len_done = (ws_phase == wsd_pkg::PH_EXT16) ? 3'd2 : 3'd0;
            rem_len  = {rem_len[55:0], rx};
            hdr_cnt  = hdr_cnt + 3'd1;
            if (hdr_cnt == len_done)
               finish_length();
            return 1'b0;
         end
         wsd_pkg::PH_MASK: begin
            key_word = {key_word[23:0], rx};
            hdr_cnt  = hdr_cnt + 3'd1;
            if (hdr_cnt == 3'(KEY_BYTES)) begin
               hdr_cnt  = '0;
               key_pos  = '0;
               ws_phase = (rem_len == 64'd0) ? wsd_pkg::PH_B0 : wsd_pkg::PH_DATA;
            end
            return 1'b0;
         end
         wsd_pkg::PH_DATA: begin
            key_byte    = key_on ? key_word[8*(3-int'(key_pos)) +: 8] : 8'h00;
            rem_len     = rem_len - 64'd1;
            beat.data   = rx ^ key_byte;
            beat.opcode = frame_opc;
            beat.fin    = frame_fin;
            beat.last   = (rem_len == 64'd0);
            key_pos     = key_pos + 2'd1;
            if (beat.last)
               ws_phase = wsd_pkg::PH_B0;
            return 1'b1;
         end
         default: begin
            frame_fin = rx[7];
            frame_opc = rx[3:0];
            ws_phase  = wsd_pkg::PH_B1;
            return 1'b0;
         end
      endcase
   endfunction

   // Offer one byte after a random gap; on acceptance record what should come out
   task automatic send_byte(input logic [7:0] rx, input row_kind_type kind,
                            input payload_beat_type fixed_beat);
      int               gap;
      payload_beat_type beat;
      bit               got;
      gap = no_idle ? 0 : $urandom_range(0, 4);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      do @(posedge clock); while (!req_tready);
      got = deframe_byte(rx, beat);
      if (kind == ROW_FIXED)
         pending_beats = {pending_beats, fixed_beat};
      else if (got)
         pending_beats = {pending_beats, beat};
      bytes_sent++;
   endtask

   task automatic idle_req();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Hold the sender until every outstanding beat has come back
   task automatic drain_beats();
      idle_req();
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   // One frame with random header byte, length form, key and payload; cut short when huge_len
   task automatic send_frame(input bit huge_len);
      logic [7:0]  b0;
      logic        masked;
      int          sel;
      logic [6:0]  code;
      logic [63:0] len;
      int          n_payload;
      b0     = 8'($urandom);
      masked = 1'($urandom_range(0, 1));
      sel    = $urandom_range(0, 9);
      if (huge_len) begin
         // MSB set in the 64-bit length: counted as is, the frame never ends
         code = CODE_LEN64;
         len  = 64'h8000_0000_0000_0000;
      end else if (sel < 6) begin
         len  = 64'($urandom_range(0, 8));
         code = len[6:0];
      end else if (sel == 6) begin
         len  = 64'($urandom_range(9, 125));
         code = len[6:0];
      end else if (sel < 9) begin
         code = CODE_LEN16;
         len  = ($urandom_range(0, 3) == 0) ? 64'($urandom_range(126, 300))
                                             : 64'($urandom_range(0, 12));
      end else begin
         code = CODE_LEN64;
         len  = 64'($urandom_range(0, 12));
      end
      n_payload = huge_len ? 16 : int'(len);

      send_byte(b0, ROW_PREDICT, NO_BEAT);
      send_byte({masked, code}, ROW_PREDICT, NO_BEAT);
      if (code == CODE_LEN16) begin
         send_byte(len[15:8], ROW_PREDICT, NO_BEAT);
         send_byte(len[7:0],  ROW_PREDICT, NO_BEAT);
      end else if (code == CODE_LEN64) begin
         for (int i = 7; i >= 0; i--)
            send_byte(len[8*i +: 8], ROW_PREDICT, NO_BEAT);
      end
      if (masked)
         repeat (KEY_BYTES) send_byte(8'($urandom), ROW_PREDICT, NO_BEAT);
      repeat (n_payload) send_byte(8'($urandom), ROW_PREDICT, NO_BEAT);
   endtask

   // Receiver: random stall before each beat, none while no_idle is set
   initial begin
      int stall;
      wait (!reset);
      @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 4);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Result checker: every beat against the oldest outstanding one
   always @(posedge clock) begin
      payload_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_beats.size() == 0) begin
            $error("unexpected beat: payload_byte %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("payload_byte mismatch: expected %h, actual %h", want.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tuser[3:0] !== want.opcode) begin
               $error("frame_opcode mismatch: expected %h, actual %h",
                      want.opcode, rsp_tuser[3:0]);
               fail_count++;
            end
            if (rsp_tuser[4] !== want.fin) begin
               $error("frame_fin mismatch: expected %b, actual %b", want.fin, rsp_tuser[4]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_in_frame mismatch: expected %b, actual %b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Main sequence
   initial begin
      int n_frames;
      n_frames = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int i = 0; i < N_ROWS; i++)
         send_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].beat);
      drain_beats();

      // random frames, with stretches of no idling and occasional full drains
      while (bytes_sent < 850) begin
         no_idle = ($urandom_range(0, 3) == 0);
         send_frame(1'b0);
         n_frames++;
         if (n_frames % 40 == 0)
            drain_beats();
      end

      // closing frame with the length MSB set
      no_idle = 1'b0;
      send_frame(1'b1);
      drain_beats();
      repeat (10) @(posedge clock);

      if (fail_count == 0 && pending_beats.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
